>>> rtl/bere_pkg.sv
`timescale 1ns / 1ps

package bere_pkg;

    // Border coordinates are 10 bits, so position arithmetic wraps at 1024.
    localparam int GRID_SIZE = 1024;
    localparam int POS_W     = $clog2(GRID_SIZE);
    localparam int WIDTH_W   = POS_W + 1;
    localparam int ID_W      = 16;
    localparam int LINE_W    = 10;
    localparam int CLU_W     = 10;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = WIDTH_W'(6);

    typedef enum logic [0:0] {
        REG_END_STYLE = 1'b0,
        REG_MAX_WIDTH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic               end_style;
        logic [WIDTH_W-1:0] max_width;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]  cell_pos;
        logic              near_blocked;
        logic              far_blocked;
        logic              segment_last;
        logic [LINE_W-1:0] border_line;
        logic              orientation;
        logic [CLU_W-1:0]  cluster_row;
        logic [CLU_W-1:0]  cluster_col;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [POS_W-1:0]   pos;
        logic [LINE_W-1:0]  line;
        logic [WIDTH_W-1:0] width;
        logic               orientation;
        logic [CLU_W-1:0]   cluster_row;
        logic [CLU_W-1:0]   cluster_col;
        logic               last;
    } t_entrance;

    // Words handed from the run tracker to the output queue together, in a single push.
    typedef struct packed {
        logic [1:0] cnt;
        t_entrance  e0;
        t_entrance  e1;
    } t_push;

endpackage

>>> rtl/bere_cfg.sv
`timescale 1ns / 1ps

module bere_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bere_pkg::APB_AW-1:0] paddr,
    input  logic [bere_pkg::APB_DW-1:0] pwdata,
    output logic [bere_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output bere_pkg::t_cfg             o_cfg
);
    import bere_pkg::*;

    logic               r_end_style;
    logic [WIDTH_W-1:0] r_max_width;
    logic               w_wr;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_style <= 1'b0;
            r_max_width <= MAX_WIDTH_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_END_STYLE: r_end_style <= pwdata[0];
                REG_MAX_WIDTH: r_max_width <= pwdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_END_STYLE: prdata = {{(APB_DW-1){1'b0}}, r_end_style};
            REG_MAX_WIDTH: prdata = {{(APB_DW-WIDTH_W){1'b0}}, r_max_width};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.end_style = r_end_style;
    assign o_cfg.max_width = r_max_width;

endmodule

>>> rtl/bere_run.sv
`timescale 1ns / 1ps

module bere_run (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bere_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    input  bere_pkg::t_item i_item,
    output logic            o_in_stall,
    input  logic [1:0]      i_free,
    output bere_pkg::t_push o_push
);
    import bere_pkg::*;

    logic               r_in_valid;
    t_item              r_in;
    logic               r_run_open;
    logic [POS_W-1:0]   r_run_first;
    logic [ID_W-1:0]    r_next_id;

    logic               w_blocked;
    logic               w_close;
    logic [POS_W-1:0]   w_first;
    logic [POS_W-1:0]   w_end;
    logic [POS_W-1:0]   w_diff;
    logic [WIDTH_W-1:0] w_width;
    logic [POS_W-1:0]   w_mid;
    logic               w_split;
    logic [1:0]         w_need;
    logic               w_adv;
    logic               w_accept;
    t_entrance          w_e0;
    t_entrance          w_e1;

    // A blocked pair ends an open run one position back; an open pair on the
    // last position of a segment ends the run including itself.
    assign w_blocked = r_in.near_blocked | r_in.far_blocked;
    assign w_first   = r_run_open ? r_run_first : r_in.cell_pos;
    assign w_close   = w_blocked ? r_run_open : r_in.segment_last;
    assign w_end     = w_blocked ? (r_in.cell_pos - POS_W'(1)) : r_in.cell_pos;
    assign w_diff    = w_end - w_first;
    assign w_width   = {1'b0, w_diff} + WIDTH_W'(1);
    assign w_mid     = w_first + {1'b0, w_diff[POS_W-1:1]};
    assign w_split   = i_cfg.end_style & (w_width > i_cfg.max_width);
    assign w_need    = !w_close ? 2'd0 : (w_split ? 2'd2 : 2'd1);

    assign w_adv      = r_in_valid & (w_need <= i_free);
    assign o_in_stall = r_in_valid & ~w_adv;
    assign w_accept   = i_in_valid & ~o_in_stall;

    always_comb begin
        w_e0.id          = r_next_id;
        w_e0.pos         = w_split ? w_first : w_mid;
        w_e0.line        = r_in.border_line;
        w_e0.width       = w_split ? WIDTH_W'(1) : w_width;
        w_e0.orientation = r_in.orientation;
        w_e0.cluster_row = r_in.cluster_row;
        w_e0.cluster_col = r_in.cluster_col;
        w_e0.last        = ~w_split;

        w_e1             = w_e0;
        w_e1.id          = r_next_id + ID_W'(1);
        w_e1.pos         = w_end;
        w_e1.width       = WIDTH_W'(1);
        w_e1.last        = 1'b1;
    end

    assign o_push.cnt = w_adv ? w_need : 2'd0;
    assign o_push.e0  = w_e0;
    assign o_push.e1  = w_e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_run_open  <= 1'b0;
            r_run_first <= '0;
            r_next_id   <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_next_id <= r_next_id + ID_W'(w_need);
                if (w_close) begin
                    r_run_open <= 1'b0;
                end else if (!w_blocked) begin
                    r_run_open  <= 1'b1;
                    r_run_first <= w_first;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_item;
        end
    end

    a_close_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_close) |=> !r_run_open)
        else $error("run still open after it was closed");

    a_id_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_next_id == $past(r_next_id) + ID_W'($past(w_need)))
        else $error("entrance id counter out of step with emitted words");

    a_split_is_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> (o_push.e0.width == WIDTH_W'(1) && !o_push.e0.last))
        else $error("split run produced a wide or final first entrance");

endmodule

>>> rtl/bere_outq.sv
`timescale 1ns / 1ps

module bere_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bere_pkg::t_push     i_push,
    output logic [1:0]          o_free,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bere_pkg::t_entrance o_head
);
    import bere_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_entrance  r_q0;
    t_entrance  r_q1;
    t_entrance  n_q0;
    t_entrance  n_q1;
    logic       w_pop;
    logic [1:0] w_base;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_head      = r_q0;
    assign w_pop       = o_out_valid & ~i_out_stall;
    assign w_base      = r_cnt - {1'b0, w_pop};
    // Room counts the slot freed by a word leaving in this same cycle.
    assign o_free      = 2'd2 - w_base;
    assign n_cnt       = w_base + i_push.cnt;

    always_comb begin
        n_q0 = w_pop ? r_q1 : r_q0;
        n_q1 = r_q1;
        if (i_push.cnt != 2'd0) begin
            if (w_base == 2'd0) begin
                n_q0 = i_push.e0;
            end else begin
                n_q1 = i_push.e0;
            end
        end
        if (i_push.cnt == 2'd2) begin
            n_q1 = i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("output queue count beyond its depth");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt <= o_free)
        else $error("entrances pushed without room in the output queue");

    a_split_pair_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0 && !r_q0.last) |-> r_cnt == 2'd2)
        else $error("first end entrance queued without its partner");

endmodule

>>> rtl/border_entrance_run_detector.sv
`timescale 1ns / 1ps

// Border entrance run detector.
// Input channel (i_in_valid / o_in_stall) takes one cell pair of a cluster
// border per word. Output channel (o_out_valid / i_out_stall) gives one
// entrance per word; run_last marks the last entrance caused by a pair.
// Configuration (end_style at 0x0, max_width at 0x4) is written through the
// APB port by the user, only while the block is idle; the block itself does
// not enforce this. A pair accepted on the input is registered, evaluated,
// and its entrances go into the output queue, whose head drives the output.
// Throughput: one pair per cycle. A wide run in end style yields two words,
// which the two-entry output queue drains one per cycle; the input stalls
// only when that queue has no room for the words the held pair produces.
// When the receiver stalls, the queue fills, then the input register holds
// its pair and o_in_stall rises, so nothing is lost.
// Reset clears the open run, the entrance id counter (to 0), the queue, and
// sets end_style to 0 and max_width to 6.
module border_entrance_run_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bere_pkg::APB_AW-1:0]   paddr,
    input  logic [bere_pkg::APB_DW-1:0]   pwdata,
    output logic [bere_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bere_pkg::POS_W-1:0]    i_cell_pos,
    input  logic                          i_near_blocked,
    input  logic                          i_far_blocked,
    input  logic                          i_segment_last,
    input  logic [bere_pkg::LINE_W-1:0]   i_border_line,
    input  logic                          i_orientation,
    input  logic [bere_pkg::CLU_W-1:0]    i_cluster_row,
    input  logic [bere_pkg::CLU_W-1:0]    i_cluster_col,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bere_pkg::ID_W-1:0]     o_entrance_id,
    output logic [bere_pkg::POS_W-1:0]    o_entrance_pos,
    output logic [bere_pkg::LINE_W-1:0]   o_entrance_line,
    output logic [bere_pkg::WIDTH_W-1:0]  o_entrance_width,
    output logic                          o_out_orientation,
    output logic [bere_pkg::CLU_W-1:0]    o_out_cluster_row,
    output logic [bere_pkg::CLU_W-1:0]    o_out_cluster_col,
    output logic                          o_run_last
);
    import bere_pkg::*;

    t_cfg       w_cfg;
    t_item      w_item;
    t_push      w_push;
    t_entrance  w_head;
    logic [1:0] w_free;

    assign w_item.cell_pos     = i_cell_pos;
    assign w_item.near_blocked = i_near_blocked;
    assign w_item.far_blocked  = i_far_blocked;
    assign w_item.segment_last = i_segment_last;
    assign w_item.border_line  = i_border_line;
    assign w_item.orientation  = i_orientation;
    assign w_item.cluster_row  = i_cluster_row;
    assign w_item.cluster_col  = i_cluster_col;

    bere_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bere_run u_run (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .i_item     (w_item),
        .o_in_stall (o_in_stall),
        .i_free     (w_free),
        .o_push     (w_push)
    );

    bere_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_head      (w_head)
    );

    assign o_entrance_id     = w_head.id;
    assign o_entrance_pos    = w_head.pos;
    assign o_entrance_line   = w_head.line;
    assign o_entrance_width  = w_head.width;
    assign o_out_orientation = w_head.orientation;
    assign o_out_cluster_row = w_head.cluster_row;
    assign o_out_cluster_col = w_head.cluster_col;
    assign o_run_last        = w_head.last;

endmodule
